@@ sv/wmf_pkg.sv @@
package wmf_pkg;

    localparam int PIX_W      = 8;
    localparam int NUM_CH     = 3;
    localparam int PX_W       = PIX_W * NUM_CH;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

    localparam logic [2:0]            KERNEL_RESET = 3'd3;
    localparam logic [CFG_DATA_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [CFG_DATA_W-1:0] HEIGHT_RESET = 11'd480;

    localparam logic KIND_FLUSH = 1'b1;

    localparam int DEF_MAX_KERNEL = 5;
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef logic [PIX_W-1:0] chan_t;
    typedef logic [PX_W-1:0]  px_t;

    typedef struct packed {
        px_t  px;
        logic last;
    } out_word_t;

endpackage

@@ sv/wmf_line_mem.sv @@
module wmf_line_mem #(
    parameter int DEPTH = 1024,
    parameter int DW    = 96,
    parameter int AW    = 10
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr_a,
    input  logic [AW-1:0] raddr_b,
    output logic [DW-1:0] rdata_a,
    output logic [DW-1:0] rdata_b
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

@@ sv/wmf_median_lane.sv @@
module wmf_median_lane #(
    parameter int WIN = 5,
    parameter int R_W = 2
) (
    input  logic                             clk,
    input  logic [WIN*WIN-1:0][wmf_pkg::PIX_W-1:0] vals,
    input  logic [R_W-1:0]                   radius,
    output wmf_pkg::chan_t                   median
);
    import wmf_pkg::*;

    localparam int N    = WIN * WIN;
    localparam int RK_W = $clog2(N);

    logic [N-1:0][N-1:0] cmp_next;
    logic [N-1:0][N-1:0] cmp_reg;
    logic [N-1:0]        act;
    logic [N-1:0]        act_a_reg;
    logic [N-1:0]        act_b_reg;
    chan_t               val_a_reg [N];
    chan_t               val_b_reg [N];
    logic [RK_W-1:0]     rank_reg [N];
    logic [RK_W-1:0]     mid;
    chan_t               median_next;

    // stage a: pairwise order, ties broken by position
    always_comb
    begin
        int lo;
        lo = WIN - 1 - 2 * int'(radius);
        for (int i = 0; i < WIN; i++)
        begin
            for (int j = 0; j < WIN; j++)
            begin
                act[i*WIN+j] = (i >= lo) && (j >= lo);
            end
        end
        for (int k = 0; k < N; k++)
        begin
            for (int m = 0; m < N; m++)
            begin
                cmp_next[k][m] = act[m] && ((vals[m] < vals[k]) ||
                                 ((vals[m] == vals[k]) && (m < k)));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_reg   <= cmp_next;
        act_a_reg <= act;
        for (int k = 0; k < N; k++)
        begin
            val_a_reg[k] <= vals[k];
        end
    end

    // stage b: rank of each element
    always_ff @(posedge clk)
    begin
        act_b_reg <= act_a_reg;
        for (int k = 0; k < N; k++)
        begin
            val_b_reg[k] <= val_a_reg[k];
            rank_reg[k]  <= RK_W'($countones(cmp_reg[k]));
        end
    end

    // stage c: pick the element of middle rank
    always_comb
    begin
        mid = RK_W'(2 * int'(radius) * (int'(radius) + 1));
        median_next = '0;
        for (int k = 0; k < N; k++)
        begin
            if (act_b_reg[k] && (rank_reg[k] == mid))
            begin
                median_next = median_next | val_b_reg[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        median <= median_next;
    end

endmodule

@@ sv/wmf_out_fifo.sv @@
module wmf_out_fifo (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    input  wmf_pkg::out_word_t                  push_word,
    input  logic                                pop,
    output wmf_pkg::out_word_t                  head,
    output logic                                not_empty,
    output logic [wmf_pkg::FIFO_CNT_W-1:0]      count
);
    import wmf_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);

    out_word_t        buf_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] count_reg;
    logic [FIFO_CNT_W-1:0] count_next;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_ptr_reg] <= push_word;
        end
    end

    assign head      = buf_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign count     = count_reg;

endmodule

@@ sv/window_median_filter.sv @@
// channel  | handshake            | payload
// cfg      | cfg_write            | cfg_index, cfg_data
// in       | in_valid / in_ready  | kind, pixel_ch0..pixel_ch2
// out      | out_valid / out_ready| result_ch0..result_ch2, frame_end
//
// one word per cycle sustained while in_ready is high; each result is registered
// through line memory read, rank compare, rank count and pick, then queued.
// results lag pixels by radius rows plus radius pixels; flush words drain the tail.
// reset: rst_n async, clears positions, counters, window and queue; line memory
// is not cleared. in_ready drops only when the eight-word output queue plus the
// words in flight would overflow, so out_ready low stalls input after that.
module window_median_filter #(
    parameter int MAX_KERNEL = wmf_pkg::DEF_MAX_KERNEL,
    parameter int MAX_WIDTH  = wmf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = wmf_pkg::DEF_MAX_HEIGHT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [wmf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [wmf_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              kind,
    input  wmf_pkg::chan_t                    pixel_ch0,
    input  wmf_pkg::chan_t                    pixel_ch1,
    input  wmf_pkg::chan_t                    pixel_ch2,
    output logic                              out_valid,
    input  logic                              out_ready,
    output wmf_pkg::chan_t                    result_ch0,
    output wmf_pkg::chan_t                    result_ch1,
    output wmf_pkg::chan_t                    result_ch2,
    output logic                              frame_end
);
    import wmf_pkg::*;

    localparam int WIN     = MAX_KERNEL;
    localparam int LINES   = MAX_KERNEL - 1;
    localparam int ODD_MAX = (MAX_KERNEL - 1) | 1;
    localparam int RMAX    = ODD_MAX / 2;
    localparam int R_W     = $clog2(RMAX + 1);
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int W_W     = $clog2(MAX_WIDTH + 1);
    localparam int H_W     = $clog2(MAX_HEIGHT + 1);
    localparam int PEND_W  = $clog2(RMAX * MAX_WIDTH + RMAX + 1);
    localparam int BK_W    = $clog2(LINES);
    localparam int VEC_W   = LINES * PX_W;

    // configuration
    logic [2:0]            kernel_reg;
    logic [CFG_DATA_W-1:0] fw_reg;
    logic [CFG_DATA_W-1:0] fh_reg;
    logic                  cfg_hit;

    logic [W_W-1:0]    eff_w;
    logic [H_W-1:0]    eff_h;
    logic [R_W-1:0]    radius;
    logic [PEND_W-1:0] lag;
    logic [BK_W-1:0]   back_lag;
    logic [BK_W-1:0]   back_flush;

    // stream position
    logic [COL_W-1:0]  in_col_reg, in_col_next;
    logic [ROW_W-1:0]  in_row_reg, in_row_next;
    logic [COL_W-1:0]  ox_reg, ox_next;
    logic [ROW_W-1:0]  oy_reg, oy_next;
    logic [PEND_W-1:0] pending_reg, pending_next;

    logic            acc;
    logic            pix_acc;
    logic            flush_ok;
    logic            out_pix;
    logic            emit0;
    logic            med0;
    logic            last0;
    logic [BK_W-1:0] back0;

    // stage 1
    logic             s1_pix_reg, s1_emit_reg;
    logic             s1_med_reg, s1_last_reg;
    logic [COL_W-1:0] s1_col_reg, s1_ox_reg;
    logic [BK_W-1:0]  s1_back_reg;
    px_t              s1_px_reg;

    logic             lw_valid_reg;
    logic [COL_W-1:0] lw_col_reg;
    logic [VEC_W-1:0] lw_vec_reg;

    logic [VEC_W-1:0] rd_a, rd_b;
    logic [VEC_W-1:0] col_a, col_b, new_vec;
    px_t              pass1;

    px_t win_reg  [WIN][WIN];
    px_t win_next [WIN][WIN];

    // later stages
    logic p2_emit_reg, p3_emit_reg, p4_emit_reg;
    logic p2_med_reg, p3_med_reg, p4_med_reg;
    logic p2_last_reg, p3_last_reg, p4_last_reg;
    px_t  p2_pass_reg, p3_pass_reg, p4_pass_reg;

    logic [NUM_CH-1:0][WIN*WIN-1:0][PIX_W-1:0] lane_vals;
    chan_t lane_med [NUM_CH];

    out_word_t             push_word;
    out_word_t             head;
    logic                  fifo_ne;
    logic [FIFO_CNT_W-1:0] fifo_cnt;
    logic                  out_pop;

    assign cfg_hit = cfg_write && ((cfg_index == CFG_KERNEL) || (cfg_index == CFG_WIDTH) ||
                                   (cfg_index == CFG_HEIGHT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_reg <= KERNEL_RESET;
            fw_reg     <= WIDTH_RESET;
            fh_reg     <= HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_KERNEL: kernel_reg <= cfg_data[2:0];
                CFG_WIDTH:  fw_reg     <= cfg_data;
                CFG_HEIGHT: fh_reg     <= cfg_data;
                default:    ;
            endcase
        end
    end

    // derived frame geometry
    always_comb
    begin
        int bl;
        int bf;
        if (fw_reg == '0)
        begin
            eff_w = W_W'(1);
        end
        else if (32'(fw_reg) > MAX_WIDTH)
        begin
            eff_w = W_W'(MAX_WIDTH);
        end
        else
        begin
            eff_w = W_W'(fw_reg);
        end
        if (fh_reg == '0)
        begin
            eff_h = H_W'(1);
        end
        else if (32'(fh_reg) > MAX_HEIGHT)
        begin
            eff_h = H_W'(MAX_HEIGHT);
        end
        else
        begin
            eff_h = H_W'(fh_reg);
        end
        if (!kernel_reg[0])
        begin
            radius = '0;
        end
        else if (32'(kernel_reg) > ODD_MAX)
        begin
            radius = R_W'(RMAX);
        end
        else
        begin
            radius = R_W'(kernel_reg >> 1);
        end
        lag = PEND_W'(32'(radius) * 32'(eff_w) + 32'(radius));
        bl = 0;
        bf = 0;
        for (int k = 1; k < LINES; k++)
        begin
            if (32'(lag) >= 32'(k) * 32'(eff_w))
            begin
                bl = bl + 1;
            end
            if (32'(pending_reg) >= 32'(k) * 32'(eff_w) + 32'd1)
            begin
                bf = bf + 1;
            end
        end
        back_lag   = BK_W'(bl);
        back_flush = BK_W'(bf);
    end

    // word acceptance and position bookkeeping
    assign in_ready = (int'(fifo_cnt) + int'(s1_emit_reg) + int'(p2_emit_reg) +
                       int'(p3_emit_reg) + int'(p4_emit_reg)) < FIFO_DEPTH;
    assign acc      = in_valid && in_ready;
    assign pix_acc  = acc && (kind != KIND_FLUSH);
    assign flush_ok = acc && (kind == KIND_FLUSH) && (in_row_reg == '0) &&
                      (in_col_reg == '0) && (pending_reg != '0);
    assign out_pix  = pix_acc && ((32'(pending_reg) + 32'd1) > 32'(lag));
    assign emit0    = out_pix || flush_ok;
    assign last0    = (32'(ox_reg) + 32'd1 == 32'(eff_w)) &&
                      (32'(oy_reg) + 32'd1 == 32'(eff_h));
    assign med0     = out_pix && (radius != '0) &&
                      (32'(oy_reg) >= 32'(radius)) &&
                      (32'(oy_reg) + 32'(radius) < 32'(eff_h)) &&
                      (32'(ox_reg) >= 32'(radius)) &&
                      (32'(ox_reg) + 32'(radius) < 32'(eff_w));
    assign back0    = out_pix ? back_lag : back_flush;

    always_comb
    begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        ox_next      = ox_reg;
        oy_next      = oy_reg;
        pending_next = pending_reg;
        if (pix_acc)
        begin
            if (32'(in_col_reg) + 32'd1 >= 32'(eff_w))
            begin
                in_col_next = '0;
                if (32'(in_row_reg) + 32'd1 >= 32'(eff_h))
                begin
                    in_row_next = '0;
                end
                else
                begin
                    in_row_next = in_row_reg + 1'b1;
                end
            end
            else
            begin
                in_col_next = in_col_reg + 1'b1;
            end
            if (!out_pix)
            begin
                pending_next = pending_reg + 1'b1;
            end
        end
        if (flush_ok)
        begin
            pending_next = pending_reg - 1'b1;
        end
        if (emit0)
        begin
            if (32'(ox_reg) + 32'd1 >= 32'(eff_w))
            begin
                ox_next = '0;
                if (last0)
                begin
                    oy_next = '0;
                end
                else
                begin
                    oy_next = oy_reg + 1'b1;
                end
            end
            else
            begin
                ox_next = ox_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            ox_reg      <= '0;
            oy_reg      <= '0;
            pending_reg <= '0;
        end
        else if (cfg_hit)
        begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            ox_reg      <= '0;
            oy_reg      <= '0;
            pending_reg <= '0;
        end
        else
        begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            ox_reg      <= ox_next;
            oy_reg      <= oy_next;
            pending_reg <= pending_next;
        end
    end

    // stage 1 control and payload
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_pix_reg   <= 1'b0;
            s1_emit_reg  <= 1'b0;
            lw_valid_reg <= 1'b0;
        end
        else
        begin
            s1_pix_reg  <= pix_acc;
            s1_emit_reg <= emit0;
            if (s1_pix_reg)
            begin
                lw_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s1_med_reg  <= med0;
        s1_last_reg <= last0;
        s1_col_reg  <= in_col_reg;
        s1_ox_reg   <= ox_reg;
        s1_back_reg <= back0;
        s1_px_reg   <= {pixel_ch2, pixel_ch1, pixel_ch0};
        if (s1_pix_reg)
        begin
            lw_col_reg <= s1_col_reg;
            lw_vec_reg <= new_vec;
        end
    end

    wmf_line_mem #(
        .DEPTH (MAX_WIDTH),
        .DW    (VEC_W),
        .AW    (COL_W)
    ) u_line_mem (
        .clk     (clk),
        .we      (s1_pix_reg),
        .waddr   (s1_col_reg),
        .wdata   (new_vec),
        .raddr_a (in_col_reg),
        .raddr_b (ox_reg),
        .rdata_a (rd_a),
        .rdata_b (rd_b)
    );

    // forward the write that raced the read
    always_comb
    begin
        int sel;
        col_a   = (lw_valid_reg && (lw_col_reg == s1_col_reg)) ? lw_vec_reg : rd_a;
        new_vec = {s1_px_reg, col_a[VEC_W-1:PX_W]};
        if (s1_pix_reg && (s1_ox_reg == s1_col_reg))
        begin
            col_b = new_vec;
        end
        else if (lw_valid_reg && (lw_col_reg == s1_ox_reg))
        begin
            col_b = lw_vec_reg;
        end
        else
        begin
            col_b = rd_b;
        end
        sel   = LINES - 1 - int'(s1_back_reg);
        pass1 = '0;
        for (int e = 0; e < LINES; e++)
        begin
            if (e == sel)
            begin
                pass1 = col_b[e*PX_W +: PX_W];
            end
        end
    end

    // window shift
    always_comb
    begin
        for (int i = 0; i < WIN; i++)
        begin
            for (int j = 0; j < WIN; j++)
            begin
                if (!s1_pix_reg)
                begin
                    win_next[i][j] = win_reg[i][j];
                end
                else if (j < WIN - 1)
                begin
                    win_next[i][j] = win_reg[i][j+1];
                end
                else if (i < LINES)
                begin
                    win_next[i][j] = col_a[i*PX_W +: PX_W];
                end
                else
                begin
                    win_next[i][j] = s1_px_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WIN; i++)
            begin
                for (int j = 0; j < WIN; j++)
                begin
                    win_reg[i][j] <= '0;
                end
            end
        end
        else
        begin
            for (int i = 0; i < WIN; i++)
            begin
                for (int j = 0; j < WIN; j++)
                begin
                    win_reg[i][j] <= win_next[i][j];
                end
            end
        end
    end

    // one lane per channel
    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            for (int i = 0; i < WIN; i++)
            begin
                for (int j = 0; j < WIN; j++)
                begin
                    lane_vals[c][i*WIN+j] = win_next[i][j][c*PIX_W +: PIX_W];
                end
            end
        end
    end

    for (genvar c = 0; c < NUM_CH; c++)
    begin : g_lane
        wmf_median_lane #(
            .WIN (WIN),
            .R_W (R_W)
        ) u_lane (
            .clk    (clk),
            .vals   (lane_vals[c]),
            .radius (radius),
            .median (lane_med[c])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p2_emit_reg <= 1'b0;
            p3_emit_reg <= 1'b0;
            p4_emit_reg <= 1'b0;
        end
        else
        begin
            p2_emit_reg <= s1_emit_reg;
            p3_emit_reg <= p2_emit_reg;
            p4_emit_reg <= p3_emit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p2_med_reg  <= s1_med_reg;
        p3_med_reg  <= p2_med_reg;
        p4_med_reg  <= p3_med_reg;
        p2_last_reg <= s1_last_reg;
        p3_last_reg <= p2_last_reg;
        p4_last_reg <= p3_last_reg;
        p2_pass_reg <= pass1;
        p3_pass_reg <= p2_pass_reg;
        p4_pass_reg <= p3_pass_reg;
    end

    // merge lanes or pass the stored pixel
    assign push_word.px   = p4_med_reg ? {lane_med[2], lane_med[1], lane_med[0]} : p4_pass_reg;
    assign push_word.last = p4_last_reg;

    assign out_pop = out_valid && out_ready;

    wmf_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (p4_emit_reg),
        .push_word (push_word),
        .pop       (out_pop),
        .head      (head),
        .not_empty (fifo_ne),
        .count     (fifo_cnt)
    );

    assign out_valid  = fifo_ne;
    assign result_ch0 = head.px[PIX_W-1:0];
    assign result_ch1 = head.px[2*PIX_W-1:PIX_W];
    assign result_ch2 = head.px[3*PIX_W-1:2*PIX_W];
    assign frame_end  = head.last;

`ifndef SYNTH
    a_fifo_room: assert property (@(posedge clk) disable iff (!rst_n)
        p4_emit_reg |-> ((int'(fifo_cnt) < FIFO_DEPTH) || out_pop))
        else $error("output queue overflow");

    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= lag)
        else $error("pending count beyond lag");

    a_out_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(ox_reg) < 32'(eff_w)) && (32'(oy_reg) < 32'(eff_h)))
        else $error("output position outside frame");
`endif

endmodule
